>>> sv/mhb_pkg.sv
// ----------------------------------------------------------------------------
// mhb_pkg
// shared widths, defaults and the signed compare used by the min-heap build
// ----------------------------------------------------------------------------
`default_nettype none

package mhb_pkg;

  localparam int unsigned DataW        = 32;
  localparam int unsigned DepthDefault = 64;

  typedef logic [DataW-1:0] data_t;

  // signed a <= signed b on two's complement patterns
  function automatic logic le_signed(input data_t a, input data_t b);
    le_signed = ($signed(a) <= $signed(b));
  endfunction

endpackage

`default_nettype wire

>>> sv/mhb_ram.sv
// ----------------------------------------------------------------------------
// mhb_ram
// generic simple dual-port ram, one write and one registered read per cycle
// ----------------------------------------------------------------------------
`default_nettype none

module mhb_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output      logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

>>> sv/min_heap_build_top.sv
// ----------------------------------------------------------------------------
// min_heap_build_top
// loads a set of signed values, builds a binary min-heap bottom-up, streams it
// ----------------------------------------------------------------------------
//
//  channel   dir  tdata              tuser  tlast
//  s_axis    in   value[31:0]        -      last (starts the build)
//  m_axis    out  heap_value[31:0]   -      final_res (last heap element)
//
//  load: each accepted beat is written straight into the ram
//  build: per node a pick and a capture step, then per compared level a left
//    read, a left compare and a right compare with the move down, plus a write
//    in the leaf; one read port and one shared signed comparator set the pace
//  drain: a start read, then per output beat a ram read and an output reg
//  reset: no clearing pass; only the element count and sequencer are cleared
//  s_axis_tready is low from the last beat until the final output beat is taken
// ----------------------------------------------------------------------------
`default_nettype none

module min_heap_build_top #(
  parameter int unsigned DEPTH = mhb_pkg::DepthDefault
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  // input stream
  input  wire logic                     s_axis_tvalid,
  output      logic                     s_axis_tready,
  input  wire logic [mhb_pkg::DataW-1:0] s_axis_tdata,  // [31:0] value
  input  wire logic                     s_axis_tlast,   // last
  // output stream
  output      logic                     m_axis_tvalid,
  input  wire logic                     m_axis_tready,
  output      logic [mhb_pkg::DataW-1:0] m_axis_tdata,  // [31:0] heap_value
  output      logic                     m_axis_tlast    // final_res
);

  import mhb_pkg::*;

  localparam int unsigned AW = $clog2(DEPTH);      // ram address width
  localparam int unsigned CW = $clog2(DEPTH + 1);  // count width
  localparam int unsigned LW = AW + 2;             // child index width

  // sequencer codes
  localparam logic [2:0] StIdle = 3'd0;  // loading beats
  localparam logic [2:0] StNext = 3'd1;  // pick next node to sift, or start drain
  localparam logic [2:0] StLoad = 3'd2;  // capture node value
  localparam logic [2:0] StRdL  = 3'd3;  // read left child or settle
  localparam logic [2:0] StCmpL = 3'd4;  // compare left child, read right
  localparam logic [2:0] StCmpR = 3'd5;  // compare right child, move down or settle
  localparam logic [2:0] StOutW = 3'd6;  // capture ram data into output reg
  localparam logic [2:0] StOutH = 3'd7;  // hold output beat

  logic [2:0]    state_q, state_d;
  logic [CW-1:0] count_q, count_d;  // elements loaded
  logic [CW-1:0] n_q, n_d;          // elements in the build
  logic [AW-1:0] i_q, i_d;          // outer sift counter
  logic [AW-1:0] node_q, node_d;    // current hole position
  logic [AW-1:0] pick_q, pick_d;
  logic          pick_node_q, pick_node_d;
  data_t         cur_q, cur_d;      // value being sifted down
  data_t         best_q, best_d;
  logic [AW-1:0] e_q, e_d;          // drain index
  data_t         out_data_q, out_data_d;
  logic          out_last_q, out_last_d;

  // ram ports
  logic          we;
  logic [AW-1:0] waddr, raddr;
  data_t         wdata, rdata;

  // child indices and bounds
  logic [LW-1:0] left_idx, right_idx, n_ext;
  logic          left_ok, right_ok;

  // shared comparator
  data_t cmp_b;
  logic  cmp_le;

  logic          in_beat, out_beat, has_room;
  logic [CW-1:0] e_next;

  mhb_ram #(
    .Width (DataW),
    .Depth (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  assign left_idx  = {1'b0, node_q, 1'b1};
  assign right_idx = left_idx + LW'(1);
  assign n_ext     = LW'(n_q);
  assign left_ok   = (left_idx < n_ext);
  assign right_ok  = (right_idx < n_ext);

  // one comparator: left child against the sifted value, then right against best
  assign cmp_b  = (state_q == StCmpL) ? cur_q : best_q;
  assign cmp_le = le_signed(rdata, cmp_b);

  assign s_axis_tready = (state_q == StIdle);
  assign m_axis_tvalid = (state_q == StOutH);
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tlast  = out_last_q;

  assign in_beat  = s_axis_tvalid && s_axis_tready;
  assign out_beat = m_axis_tvalid && m_axis_tready;
  assign has_room = (count_q < CW'(DEPTH));
  assign e_next   = CW'(e_q) + CW'(1);

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    n_d         = n_q;
    i_d         = i_q;
    node_d      = node_q;
    pick_d      = pick_q;
    pick_node_d = pick_node_q;
    cur_d       = cur_q;
    best_d      = best_q;
    e_d         = e_q;
    out_data_d  = out_data_q;
    out_last_d  = out_last_q;
    we          = 1'b0;
    waddr       = node_q;
    wdata       = cur_q;
    raddr       = left_idx[AW-1:0];

    unique case (state_q)
      StIdle: begin
        waddr = count_q[AW-1:0];
        wdata = s_axis_tdata;
        if (in_beat) begin
          // a beat beyond the store size is dropped
          if (has_room) begin
            we      = 1'b1;
            count_d = count_q + CW'(1);
          end
          if (s_axis_tlast) begin
            n_d     = has_room ? (count_q + CW'(1)) : count_q;
            i_d     = AW'(n_d >> 1);
            state_d = StNext;
          end
        end
      end
      StNext: begin
        if (i_q == '0) begin
          raddr   = '0;
          e_d     = '0;
          state_d = StOutW;
        end else begin
          i_d     = i_q - AW'(1);
          raddr   = i_q - AW'(1);
          state_d = StLoad;
        end
      end
      StLoad: begin
        cur_d   = rdata;
        node_d  = i_q;
        state_d = StRdL;
      end
      StRdL: begin
        if (left_ok) begin
          raddr   = left_idx[AW-1:0];
          state_d = StCmpL;
        end else begin
          // leaf reached: drop the sifted value into the hole
          we      = 1'b1;
          state_d = StNext;
        end
      end
      StCmpL: begin
        raddr = right_idx[AW-1:0];
        if (cmp_le) begin
          best_d      = rdata;
          pick_d      = left_idx[AW-1:0];
          pick_node_d = 1'b0;
        end else begin
          best_d      = cur_q;
          pick_d      = node_q;
          pick_node_d = 1'b1;
        end
        state_d = StCmpR;
      end
      StCmpR: begin
        we = 1'b1;
        priority if (right_ok && cmp_le) begin
          // right child wins ties against left and parent
          wdata   = rdata;
          node_d  = right_idx[AW-1:0];
          state_d = StRdL;
        end else if (!pick_node_q) begin
          wdata   = best_q;
          node_d  = pick_q;
          state_d = StRdL;
        end else begin
          wdata   = cur_q;
          state_d = StNext;
        end
      end
      StOutW: begin
        out_data_d = rdata;
        out_last_d = (e_next == n_q);
        state_d    = StOutH;
      end
      StOutH: begin
        raddr = e_next[AW-1:0];
        if (out_beat) begin
          if (out_last_q) begin
            count_d = '0;
            state_d = StIdle;
          end else begin
            e_d     = e_next[AW-1:0];
            state_d = StOutW;
          end
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      count_q <= '0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    n_q         <= n_d;
    i_q         <= i_d;
    node_q      <= node_d;
    pick_q      <= pick_d;
    pick_node_q <= pick_node_d;
    cur_q       <= cur_d;
    best_q      <= best_d;
    e_q         <= e_d;
    out_data_q  <= out_data_d;
    out_last_q  <= out_last_d;
  end

  // checks

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(DEPTH))
    else $error("element count above store size");

  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !s_axis_tready)
    else $error("load and drain overlap");

  a_drain_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_beat && out_last_q) |=> (count_q == '0 && s_axis_tready))
    else $error("set not released after final beat");

  a_node_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StCmpL || state_q == StCmpR) |-> (CW'(node_q) < n_q))
    else $error("sift position outside the set");

  a_start_build: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_beat && s_axis_tlast) |=> (state_q == StNext && n_q != '0))
    else $error("build not started on last beat");

endmodule

`default_nettype wire
